// ===== rtl/cft_pkg.sv =====
// ----------------------------------------------------------------------------
// cft_pkg - shared types and constants for the constant fold tracker
// Field layouts of request and result, opcode and action codes, the table
// write and lookup records, and the record carried from fold to writeback.
// ----------------------------------------------------------------------------
package cft_pkg;

  localparam int NUM_VARS   = 256;
  localparam int ID_W       = 8;
  localparam int WORD_W     = 32;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1) + 1;

  typedef logic [ID_W-1:0]   id_t;
  typedef logic [WORD_W-1:0] word_t;

  // Opcodes
  localparam logic [3:0] OP_MOV   = 4'd0;
  localparam logic [3:0] OP_LSL   = 4'd1;
  localparam logic [3:0] OP_LSR   = 4'd2;
  localparam logic [3:0] OP_ASR   = 4'd3;
  localparam logic [3:0] OP_ROR   = 4'd4;
  localparam logic [3:0] OP_ADD   = 4'd5;
  localparam logic [3:0] OP_SUB   = 4'd6;
  localparam logic [3:0] OP_AND   = 4'd7;
  localparam logic [3:0] OP_BIC   = 4'd8;
  localparam logic [3:0] OP_EOR   = 4'd9;
  localparam logic [3:0] OP_ORR   = 4'd10;
  localparam logic [3:0] OP_MUL   = 4'd11;
  localparam logic [3:0] OP_OTHER = 4'd12;
  localparam logic [3:0] OP_CLEAR = 4'd13;

  // Actions
  localparam logic [1:0] ACT_KEEP = 2'd0;
  localparam logic [1:0] ACT_MOV  = 2'd1;
  localparam logic [1:0] ACT_MOVS = 2'd2;
  localparam logic [1:0] ACT_NOP  = 2'd3;

  typedef struct packed {
    logic [3:0] op;
    id_t        dest_var;
    logic       dest_present;
    id_t        dest_hi_var;
    logic       dest_hi_present;
    id_t        a_var;
    id_t        b_var;
    logic       b_is_imm;
    word_t      b_imm;
    logic       set_flags;
    logic       signed_mul;
  } cmd_t;

  typedef struct packed {
    logic       folded;
    word_t      value_lo;
    word_t      value_hi;
    logic [1:0] action;
  } res_t;

  // One table write
  typedef struct packed {
    logic  en;
    id_t   id;
    word_t data;
  } wr_t;

  // Result of a table lookup
  typedef struct packed {
    logic  known;
    word_t value;
  } look_t;

  // Table write chosen at fold time; hi selects the upper product half
  typedef struct packed {
    logic en;
    id_t  id;
    logic hi;
  } wsel_t;

  typedef struct packed {
    logic        folded;
    logic [1:0]  action;
    logic        clear;
    logic        is_mul;
    logic        is_long;
    word_t       alu_lo;
    logic [63:0] prod;
    wsel_t       first;
    wsel_t       second;
  } stage_t;

  function automatic logic id_ok(input id_t id);
    return {1'b0, id} < (ID_W+1)'(NUM_VARS);
  endfunction

endpackage

// ===== rtl/constant_fold_tracker.sv =====
// A result passes the stage 1 and 2 registers and the queue. Throughput: one
// request per cycle while the queue has room; a multiply naming both a low
// and a high result variable holds off the next request, as the table RAM
// has a single write port. Reset: known bits clear at once; the RAM is not
// swept and no clearing pass runs. Clears empty the known bits at writeback.
// ----------------------------------------------------------------------------
// constant_fold_tracker - constant propagation over intermediate code
// Stage 1 reads the table and folds, stage 2 writes back and queues the
// result. Pending table writes are forwarded into stage 1 lookups.
// ----------------------------------------------------------------------------
module constant_fold_tracker (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  cft_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_stall,
  output cft_pkg::res_t res
);

  logic                          accept;
  logic                          s1_v;
  cft_pkg::cmd_t                 s1;
  logic                          s2_v;
  cft_pkg::stage_t               s2;
  cft_pkg::look_t                a_look;
  cft_pkg::look_t                b_look;
  cft_pkg::word_t                s2_lo;
  cft_pkg::word_t                s2_hi;
  cft_pkg::wr_t                  wr_first;
  cft_pkg::wr_t                  pend;
  cft_pkg::wr_t                  wr;
  cft_pkg::wr_t                  fwd;
  logic                          s2_clr;
  cft_pkg::res_t                 result;
  logic [cft_pkg::FIFO_CW-1:0]   level;
  logic [cft_pkg::FIFO_CW-1:0]   in_flight;
  logic                          dual;

  assign accept = cmd_valid && !cmd_stall;

  // Hold off the next request behind a multiply that names both result variables
  assign dual = s1_v && (s1.op == cft_pkg::OP_MUL) && s1.dest_present
                && s1.dest_hi_present;
  assign in_flight = level + cft_pkg::FIFO_CW'(s1_v) + cft_pkg::FIFO_CW'(s2_v);
  assign cmd_stall = dual || (in_flight >= cft_pkg::FIFO_CW'(cft_pkg::FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= accept;
      s2_v <= s1_v;
    end
    s1 <= cmd;
  end

  cft_table u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_a    (cmd.a_var),
    .rd_b    (cmd.b_var),
    .wr      (wr),
    .clr     (s2_clr),
    .fwd     (fwd),
    .fwd_clr (s2_clr),
    .a_look  (a_look),
    .b_look  (b_look)
  );

  cft_fold u_fold (
    .clk    (clk),
    .s1     (s1),
    .a_look (a_look),
    .b_look (b_look),
    .s2     (s2)
  );

  // Writeback
  assign s2_lo  = s2.is_mul ? s2.prod[31:0] : s2.alu_lo;
  assign s2_hi  = s2.prod[63:32];
  assign s2_clr = s2_v && s2.clear;

  assign wr_first.en   = s2_v && s2.first.en;
  assign wr_first.id   = s2.first.id;
  assign wr_first.data = s2.first.hi ? s2_hi : s2_lo;

  assign fwd.en   = s2_v && s2.second.en;
  assign fwd.id   = s2.second.id;
  assign fwd.data = s2_hi;

  assign wr = wr_first.en ? wr_first : pend;

  // Defer the high half to the bubble cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      pend.en <= 1'b0;
    end else begin
      pend.en <= fwd.en;
    end
    pend.id   <= fwd.id;
    pend.data <= fwd.data;
  end

  assign result.folded   = s2.folded;
  assign result.value_lo = s2.folded ? s2_lo : '0;
  assign result.value_hi = (s2.folded && s2.is_long) ? s2_hi : '0;
  assign result.action   = s2.action;

  cft_out_fifo u_out_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (s2_v),
    .din   (result),
    .valid (res_valid),
    .stall (res_stall),
    .dout  (res),
    .level (level)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    in_flight <= cft_pkg::FIFO_CW'(cft_pkg::FIFO_DEPTH))
    else $error("result queue and pipeline exceed queue depth");

  a_single_write: assert property (@(posedge clk) disable iff (rst)
    pend.en |-> !wr_first.en)
    else $error("deferred high write collides with a writeback");

  a_clear_alone: assert property (@(posedge clk) disable iff (rst)
    s2_clr |-> !pend.en && !wr_first.en)
    else $error("table write alongside a clear");

  a_unfolded_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.folded |->
      res.value_lo == '0 && res.value_hi == '0 && res.action == cft_pkg::ACT_KEEP)
    else $error("unfolded result carries data");
`endif

endmodule

// ===== rtl/cft_table.sv =====
// ----------------------------------------------------------------------------
// cft_table - known-constant table
// Value store in a synchronous RAM with two read ports and one write port,
// known bits in flops. Lookups resolve in the cycle after the read is issued,
// forwarding writes that the RAM data does not yet show.
// ----------------------------------------------------------------------------
module cft_table (
  input  logic           clk,
  input  logic           rst,
  input  cft_pkg::id_t   rd_a,
  input  cft_pkg::id_t   rd_b,
  input  cft_pkg::wr_t   wr,
  input  logic           clr,
  input  cft_pkg::wr_t   fwd,
  input  logic           fwd_clr,
  output cft_pkg::look_t a_look,
  output cft_pkg::look_t b_look
);

  cft_pkg::word_t               mem [cft_pkg::NUM_VARS];
  logic [cft_pkg::NUM_VARS-1:0] valid;
  cft_pkg::word_t               q_a;
  cft_pkg::word_t               q_b;
  cft_pkg::id_t                 id_a;
  cft_pkg::id_t                 id_b;
  cft_pkg::wr_t                 last;

  always_ff @(posedge clk) begin
    if (wr.en && cft_pkg::id_ok(wr.id)) begin
      mem[wr.id] <= wr.data;
    end
    q_a  <= mem[rd_a];
    q_b  <= mem[rd_b];
    id_a <= rd_a;
    id_b <= rd_b;
  end

  // Keep the write made at the read edge: the RAM returns the old data
  always_ff @(posedge clk) begin
    if (rst) begin
      last.en <= 1'b0;
    end else begin
      last.en <= wr.en;
    end
    last.id   <= wr.id;
    last.data <= wr.data;
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      valid <= '0;
    end else if (wr.en && cft_pkg::id_ok(wr.id)) begin
      valid[wr.id] <= 1'b1;
    end
  end

  function automatic cft_pkg::look_t resolve(
    input cft_pkg::id_t   id,
    input cft_pkg::word_t q,
    input logic           vbit,
    input cft_pkg::wr_t   f,
    input cft_pkg::wr_t   w,
    input cft_pkg::wr_t   l,
    input logic           fc
  );
    cft_pkg::look_t r;
    logic           hit_f;
    logic           hit_w;
    logic           hit_l;
    hit_f   = f.en && (f.id == id);
    hit_w   = w.en && (w.id == id);
    hit_l   = l.en && (l.id == id);
    r.known = !fc && cft_pkg::id_ok(id) && (vbit || hit_f || hit_w);
    // newest write wins
    r.value = hit_f ? f.data : hit_w ? w.data : hit_l ? l.data : q;
    return r;
  endfunction

  assign a_look = resolve(id_a, q_a, valid[id_a], fwd, wr, last, fwd_clr);
  assign b_look = resolve(id_b, q_b, valid[id_b], fwd, wr, last, fwd_clr);

endmodule

// ===== rtl/cft_fold.sv =====
// ----------------------------------------------------------------------------
// cft_fold - fold stage
// Evaluates shifts, ALU ops and the 33x33 product from the resolved operands,
// picks the action and table writes, and registers them for writeback.
// ----------------------------------------------------------------------------
module cft_fold (
  input  logic            clk,
  input  cft_pkg::cmd_t   s1,
  input  cft_pkg::look_t  a_look,
  input  cft_pkg::look_t  b_look,
  output cft_pkg::stage_t s2
);

  cft_pkg::word_t        a;
  cft_pkg::word_t        b;
  logic                  a_ok;
  logic                  b_ok;
  logic [7:0]            amt;
  logic                  big;
  logic [4:0]            asr_sh;
  logic [63:0]           ror_w;
  cft_pkg::word_t        shres;
  logic                  sx;
  logic signed [32:0]    mx;
  logic signed [32:0]    my;
  logic signed [65:0]    prod_full;
  logic                  wlo;
  logic                  whi;
  cft_pkg::stage_t       nxt;

  assign a    = a_look.value;
  assign a_ok = a_look.known;
  assign b    = s1.b_is_imm ? s1.b_imm : b_look.value;
  assign b_ok = s1.b_is_imm || b_look.known;

  assign amt    = b[7:0];
  assign big    = amt[7:5] != 3'd0;
  assign asr_sh = (big || amt == 8'd0) ? 5'd31 : amt[4:0];
  assign ror_w  = {a, a} >> b[4:0];

  always_comb begin
    case (s1.op)
      cft_pkg::OP_LSL: shres = big ? '0 : a << amt[4:0];
      cft_pkg::OP_LSR: shres = (big || amt == 8'd0) ? '0 : a >> amt[4:0];
      cft_pkg::OP_ASR: shres = cft_pkg::word_t'($signed(a) >>> asr_sh);
      default:         shres = ror_w[31:0];
    endcase
  end

  // Sign-extend only for a signed long multiply; the low half is the same
  assign sx        = s1.signed_mul && s1.dest_hi_present;
  assign mx        = {sx & a[31], a};
  assign my        = {sx & b[31], b};
  assign prod_full = mx * my;

  always_comb begin
    nxt         = '0;
    nxt.prod    = prod_full[63:0];
    nxt.is_long = s1.dest_hi_present;
    case (s1.op)
      cft_pkg::OP_MOV: begin
        nxt.folded = b_ok;
        nxt.alu_lo = b;
      end
      cft_pkg::OP_LSL, cft_pkg::OP_LSR, cft_pkg::OP_ASR, cft_pkg::OP_ROR: begin
        // rotate by zero is RRX: leave it
        nxt.folded = a_ok && b_ok && !(s1.op == cft_pkg::OP_ROR && b == '0);
        nxt.alu_lo = shres;
        if (s1.dest_present && !s1.set_flags) begin
          nxt.action = cft_pkg::ACT_MOV;
        end
      end
      cft_pkg::OP_ADD, cft_pkg::OP_SUB, cft_pkg::OP_AND, cft_pkg::OP_BIC,
      cft_pkg::OP_EOR, cft_pkg::OP_ORR: begin
        nxt.folded = a_ok && b_ok;
        case (s1.op)
          cft_pkg::OP_ADD: nxt.alu_lo = a + b;
          cft_pkg::OP_SUB: nxt.alu_lo = a - b;
          cft_pkg::OP_AND: nxt.alu_lo = a & b;
          cft_pkg::OP_BIC: nxt.alu_lo = a & ~b;
          cft_pkg::OP_EOR: nxt.alu_lo = a ^ b;
          default:         nxt.alu_lo = a | b;
        endcase
        if (s1.dest_present) begin
          if (s1.op == cft_pkg::OP_ADD || s1.op == cft_pkg::OP_SUB) begin
            nxt.action = s1.set_flags ? cft_pkg::ACT_KEEP : cft_pkg::ACT_MOV;
          end else begin
            nxt.action = s1.set_flags ? cft_pkg::ACT_MOVS : cft_pkg::ACT_MOV;
          end
        end else if (!s1.set_flags) begin
          nxt.action = cft_pkg::ACT_NOP;
        end
      end
      cft_pkg::OP_MUL: begin
        nxt.folded = a_ok && b_ok;
        nxt.is_mul = 1'b1;
        if (!s1.dest_hi_present && s1.dest_present) begin
          nxt.action = s1.set_flags ? cft_pkg::ACT_MOVS : cft_pkg::ACT_MOV;
        end
      end
      cft_pkg::OP_CLEAR: begin
        nxt.clear = 1'b1;
      end
      default: begin
        nxt.folded = 1'b0;
      end
    endcase
    if (!nxt.folded) begin
      nxt.action = cft_pkg::ACT_KEEP;
    end
    nxt.is_long = nxt.is_long && nxt.is_mul;
    // low half first, high half second so it wins on a shared id
    wlo = nxt.folded && s1.dest_present;
    whi = nxt.folded && nxt.is_long;
    nxt.first.en   = wlo || whi;
    nxt.first.id   = wlo ? s1.dest_var : s1.dest_hi_var;
    nxt.first.hi   = !wlo;
    nxt.second.en  = wlo && whi;
    nxt.second.id  = s1.dest_hi_var;
    nxt.second.hi  = 1'b1;
  end

  always_ff @(posedge clk) begin
    s2 <= nxt;
  end

endmodule

// ===== rtl/cft_out_fifo.sv =====
// ----------------------------------------------------------------------------
// cft_out_fifo - result queue
// Small register queue between writeback and the result channel; its level
// lets the front end stop taking requests before the queue can overflow.
// ----------------------------------------------------------------------------
module cft_out_fifo (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  cft_pkg::res_t                din,
  output logic                         valid,
  input  logic                         stall,
  output cft_pkg::res_t                dout,
  output logic [cft_pkg::FIFO_CW-1:0]  level
);

  cft_pkg::res_t                store [cft_pkg::FIFO_DEPTH];
  logic [cft_pkg::FIFO_AW-1:0]  wr_ptr;
  logic [cft_pkg::FIFO_AW-1:0]  rd_ptr;
  logic                         pop;

  assign valid = level != '0;
  assign pop   = valid && !stall;
  assign dout  = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

endmodule
